// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, register indexes, result codes and the control/status
// bundles that pass between the allocator controller and datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF = 32;
    localparam int unsigned ADDR_BITS_DEF  = 32;

    localparam int unsigned REQ_W      = 32;
    localparam int unsigned HANDLE_W   = 5;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned INDEX_W    = 5;
    localparam int unsigned OUT_ADDR_W = 32;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned HDR_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd2;

    localparam logic [CFG_W-1:0] HEAP_BASE_RST  = 32'h0000_0000;
    localparam logic [CFG_W-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;
    localparam logic [HDR_W-1:0] HEADER_RST     = 8'd24;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic capture;
        logic prep;
        logic scan_read;
        logic hit_take;
        logic free_read;
        logic free_write;
        logic append_take;
        logic fail_nomem;
        logic fail_unknown;
        logic out_load;
    } ffba_cmd_t;

    typedef struct packed {
        logic is_free;
        logic hit;
        logic more;
        logic handle_ok;
        logic full;
        logic bad;
        logic out_busy;
    } ffba_sts_t;

endpackage

// ===== hdl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ffba_datapath.sv =====
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table RAM, configuration registers, heap top, scan pointer,
// append arithmetic and the result/output registers.
// ----------------------------------------------------------------------------
module ffba_datapath #(
    parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffba_pkg::ffba_cmd_t                cmd,
    output ffba_pkg::ffba_sts_t                sts,
    input  logic                               cfg_wr_en,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffba_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               mode,
    input  logic [ffba_pkg::REQ_W-1:0]         request_size,
    input  logic [ffba_pkg::HANDLE_W-1:0]      block_handle,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [ffba_pkg::STATUS_W-1:0]      status,
    output logic [ffba_pkg::INDEX_W-1:0]       granted_index,
    output logic [ffba_pkg::OUT_ADDR_W-1:0]    granted_address,
    output logic                               was_reused
);

    import ffba_pkg::*;

    localparam int unsigned IDX_W    = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned CMP_W    = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
    localparam int unsigned SUM_W    = ((ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W) + 2;
    localparam int unsigned WORD_W   = ADDR_BITS + REQ_W + 1;
    localparam int unsigned FREE_BIT = WORD_W - 1;

    // configuration; the heap base only acts through the heap top
    logic [CFG_W-1:0]      heap_limit_reg;
    logic [HDR_W-1:0]      header_reg;

    // table state
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_BITS-1:0]  top_reg, top_next;

    // captured request
    logic                  mode_reg;
    logic [REQ_W-1:0]      req_reg;
    logic [HANDLE_W-1:0]   handle_reg;

    // scan pipeline
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  chk_valid_reg;
    logic [IDX_W-1:0]      chk_idx_reg;

    // append arithmetic
    logic [ADDR_BITS:0]    s1_reg;
    logic [SUM_W-1:0]      s2_reg;

    // result and output
    logic [STATUS_W-1:0]   res_status_reg;
    logic [INDEX_W-1:0]    res_index_reg;
    logic [OUT_ADDR_W-1:0] res_addr_reg;
    logic                  res_reused_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [INDEX_W-1:0]    out_index_reg;
    logic [OUT_ADDR_W-1:0] out_addr_reg;
    logic                  out_reused_reg;

    // RAM
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  rd_free;
    logic [REQ_W-1:0]      rd_size;
    logic [ADDR_BITS-1:0]  rd_start;
    logic [ADDR_BITS-1:0]  rd_user_addr;
    logic [IDX_W-1:0]      handle_idx;

    assign rd_free      = ram_rdata[FREE_BIT];
    assign rd_size      = ram_rdata[ADDR_BITS +: REQ_W];
    assign rd_start     = ram_rdata[ADDR_BITS-1:0];
    assign rd_user_addr = rd_start + ADDR_BITS'(header_reg);
    assign handle_idx   = IDX_W'(handle_reg);

    ffba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = {1'b0, rd_size, rd_start};
        if (cmd.hit_take)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.free_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = handle_idx;
            ram_wdata = {1'b1, rd_size, rd_start};
        end
        else if (cmd.append_take)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = {1'b0, req_reg, top_reg};
        end
    end

    assign ram_re    = cmd.scan_read | cmd.free_read;
    assign ram_raddr = cmd.free_read ? handle_idx : rd_idx_reg[IDX_W-1:0];

    // status
    assign sts.is_free   = (mode_reg == MODE_FREE);
    assign sts.hit       = chk_valid_reg && rd_free && (rd_size >= req_reg);
    assign sts.more      = (rd_idx_reg < count_reg);
    assign sts.handle_ok = (CMP_W'(handle_reg) < CMP_W'(count_reg));
    assign sts.full      = (count_reg == CNT_W'(MAX_BLOCKS));
    assign sts.bad       = (|s2_reg[SUM_W-1:ADDR_BITS]) ||
                           (s2_reg > SUM_W'(heap_limit_reg));
    assign sts.out_busy  = out_valid_reg && out_stall;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.append_take)
        begin
            count_next = count_reg + CNT_W'(1);
            top_next   = s2_reg[ADDR_BITS-1:0];
        end
        else if (cfg_wr_en && (cfg_index == REG_HEAP_BASE) && (count_reg == '0))
        begin
            // the heap top follows the base only while the table is empty
            top_next = ADDR_BITS'(cfg_wr_data);
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.prep)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.scan_read)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= HEAP_LIMIT_RST;
            header_reg     <= HEADER_RST;
            count_reg      <= '0;
            top_reg        <= ADDR_BITS'(HEAP_BASE_RST);
            rd_idx_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_HEAP_LIMIT:   heap_limit_reg <= cfg_wr_data;
                    REG_HEADER_BYTES: header_reg     <= cfg_wr_data[HDR_W-1:0];
                    default:          ;
                endcase
            end
            count_reg     <= count_next;
            top_reg       <= top_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= cmd.scan_read;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // free-running: top plus header is registered in s1_reg, then plus the request in s2_reg
        s1_reg <= {1'b0, top_reg} + (ADDR_BITS + 1)'(header_reg);
        s2_reg <= SUM_W'(s1_reg) + SUM_W'(req_reg);

        if (cmd.capture)
        begin
            mode_reg   <= mode;
            req_reg    <= request_size;
            handle_reg <= block_handle;
        end

        if (cmd.scan_read)
        begin
            chk_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end

        if (cmd.hit_take)
        begin
            res_status_reg <= ST_OK;
            res_index_reg  <= INDEX_W'(chk_idx_reg);
            res_addr_reg   <= OUT_ADDR_W'(rd_user_addr);
            res_reused_reg <= 1'b1;
        end
        else if (cmd.free_write)
        begin
            res_status_reg <= ST_OK;
            res_index_reg  <= INDEX_W'(handle_reg);
            res_addr_reg   <= OUT_ADDR_W'(rd_user_addr);
            res_reused_reg <= 1'b0;
        end
        else if (cmd.append_take)
        begin
            res_status_reg <= ST_OK;
            res_index_reg  <= INDEX_W'(count_reg);
            res_addr_reg   <= OUT_ADDR_W'(s1_reg[ADDR_BITS-1:0]);
            res_reused_reg <= 1'b0;
        end
        else if (cmd.fail_nomem)
        begin
            res_status_reg <= ST_NOMEM;
            res_index_reg  <= '0;
            res_addr_reg   <= '0;
            res_reused_reg <= 1'b0;
        end
        else if (cmd.fail_unknown)
        begin
            res_status_reg <= ST_UNKNOWN;
            res_index_reg  <= INDEX_W'(handle_reg);
            res_addr_reg   <= '0;
            res_reused_reg <= 1'b0;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_addr_reg   <= res_addr_reg;
            out_reused_reg <= res_reused_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_index   = out_index_reg;
    assign granted_address = out_addr_reg;
    assign was_reused      = out_reused_reg;

endmodule

// ===== hdl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for the allocator: takes one request, runs the first-fit scan
// or the free, decides on append or failure, and hands off the result.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ffba_pkg::ffba_sts_t sts,
    output ffba_pkg::ffba_cmd_t cmd
);

    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PREP     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_APPEND   = 3'd3;
    localparam logic [2:0] S_FREE_CHK = 3'd4;
    localparam logic [2:0] S_FREE_WR  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = sts.is_free ? S_FREE_CHK : S_SCAN;
            end
            S_SCAN:
            begin
                // check entry read last cycle while reading the next one
                if (sts.hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = S_DONE;
                end
                else if (sts.more)
                begin
                    cmd.scan_read = 1'b1;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                if (sts.full || sts.bad)
                begin
                    cmd.fail_nomem = 1'b1;
                end
                else
                begin
                    cmd.append_take = 1'b1;
                end
                state_next = S_DONE;
            end
            S_FREE_CHK:
            begin
                if (sts.handle_ok)
                begin
                    cmd.free_read = 1'b1;
                    state_next    = S_FREE_WR;
                end
                else
                begin
                    cmd.fail_unknown = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_FREE_WR:
            begin
                cmd.free_write = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator with a table of blocks in creation order.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate scans the block table in
// RAM one entry per cycle and stops early when a free block fits. The
// single RAM read port sets the scan pace. A result waiting in the output
// register does not block acceptance of the next request, but that request
// cannot finish while the output register still holds a stalled result.
// The table needs no initialization after reset.
module first_fit_block_allocator #(
    parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffba_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [ffba_pkg::REQ_W-1:0]      request_size,
    input  logic [ffba_pkg::HANDLE_W-1:0]   block_handle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ffba_pkg::STATUS_W-1:0]   status,
    output logic [ffba_pkg::INDEX_W-1:0]    granted_index,
    output logic [ffba_pkg::OUT_ADDR_W-1:0] granted_address,
    output logic                            was_reused
);

    import ffba_pkg::*;

    ffba_cmd_t cmd;
    ffba_sts_t sts;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .mode            (mode),
        .request_size    (request_size),
        .block_handle    (block_handle),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .granted_index   (granted_index),
        .granted_address (granted_address),
        .was_reused      (was_reused)
    );

`ifndef SYNTHESIS
    a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.hit_take, cmd.free_write, cmd.append_take}))
        else $error("more than one table write in a cycle");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("output register loaded while holding a stalled result");

    a_accept_then_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (cmd.prep && in_stall))
        else $error("accepted request not started");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator. A clocked driver
// feeds allocate and free requests from a queue in random bursts, and a
// monitor checks every result against a block-table predictor kept inside
// the bench. Configuration changes happen only between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
    import ffba_pkg::*;

    localparam int unsigned TABLE_DEPTH  = MAX_BLOCKS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned PHASE_ITEMS  = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                mode;
        logic [REQ_W-1:0]    size;
        logic [HANDLE_W-1:0] handle;
    } heap_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [INDEX_W-1:0]    index;
        logic [OUT_ADDR_W-1:0] addr;
        logic                  reused;
    } heap_resp_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_wr_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    mode;
    logic [REQ_W-1:0]        request_size;
    logic [HANDLE_W-1:0]     block_handle;
    logic                    out_valid;
    logic                    out_stall;
    logic [STATUS_W-1:0]     status;
    logic [INDEX_W-1:0]      granted_index;
    logic [OUT_ADDR_W-1:0]   granted_address;
    logic                    was_reused;

    first_fit_block_allocator u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .request_size    (request_size),
        .block_handle    (block_handle),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .granted_index   (granted_index),
        .granted_address (granted_address),
        .was_reused      (was_reused)
    );

    // Predicted block table and register copies
    logic [31:0]      blk_start [TABLE_DEPTH];
    logic [31:0]      blk_size  [TABLE_DEPTH];
    logic             blk_free  [TABLE_DEPTH];
    int unsigned      blk_count;
    logic [31:0]      heap_top;
    logic [CFG_W-1:0] limit_reg;
    logic [HDR_W-1:0] hdr_reg;

    heap_req_t   pending_reqs [$];
    heap_resp_t  expected_resps [$];

    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned n_alloc, n_reuse, n_nomem, n_free, n_unknown, n_settings;
    bit          transfer_done;
    int unsigned burst_left, gap_left;
    bit          stall_on;
    int unsigned stall_run;

    task automatic allocate_or_free(input heap_req_t rq, output heap_resp_t rs);
        logic [33:0] new_top;
        bit          found;
        found = 0;
        rs    = '0;
        if (rq.mode == MODE_FREE)
        begin
            n_free++;
            rs.index = rq.handle;
            if (rq.handle >= blk_count)
            begin
                rs.status = ST_UNKNOWN;
                n_unknown++;
            end
            else
            begin
                blk_free[rq.handle] = 1'b1;
                rs.status = ST_OK;
                rs.addr   = blk_start[rq.handle] + hdr_reg;
            end
        end
        else
        begin
            n_alloc++;
            for (int i = 0; i < blk_count && !found; i++)
            begin
                if (blk_free[i] && blk_size[i] >= rq.size)
                begin
                    found       = 1;
                    blk_free[i] = 1'b0;
                    rs.status   = ST_OK;
                    rs.index    = i[INDEX_W-1:0];
                    rs.addr     = blk_start[i] + hdr_reg;
                    rs.reused   = 1'b1;
                    n_reuse++;
                end
            end
            if (!found)
            begin
                // the 34-bit sum catches both a carry and a limit overrun
                new_top = {2'b00, heap_top} + hdr_reg + rq.size;
                if (blk_count >= TABLE_DEPTH || new_top > {2'b00, limit_reg})
                begin
                    rs.status = ST_NOMEM;
                    n_nomem++;
                end
                else
                begin
                    blk_start[blk_count] = heap_top;
                    blk_size[blk_count]  = rq.size;
                    blk_free[blk_count]  = 1'b0;
                    rs.status = ST_OK;
                    rs.index  = blk_count[INDEX_W-1:0];
                    rs.addr   = heap_top + hdr_reg;
                    blk_count++;
                    heap_top  = new_top[31:0];
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_HEAP_BASE:
            begin
                if (blk_count == 0)
                    heap_top = data;
            end
            REG_HEAP_LIMIT:   limit_reg = data;
            REG_HEADER_BYTES: hdr_reg   = data[HDR_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end while (pending_reqs.size() != 0 || (in_valid && !transfer_done) ||
                   expected_resps.size() != 0);
    endtask

    task automatic push_req(input logic m, input logic [31:0] sz, input logic [4:0] h);
        heap_req_t it;
        it.mode   = m;
        it.size   = sz;
        it.handle = h;
        pending_reqs.push_back(it);
    endtask

    function automatic heap_req_t random_req();
        heap_req_t   it;
        int unsigned pick;
        int unsigned hi;
        it.mode   = ($urandom_range(0, 99) < 55) ? MODE_ALLOC : MODE_FREE;
        it.size   = $urandom;
        it.handle = HANDLE_W'($urandom);
        hi   = (blk_count > 0) ? blk_count - 1 : 0;
        pick = $urandom_range(0, 99);
        if (it.mode == MODE_FREE)
        begin
            if (pick < 80)
                it.handle = HANDLE_W'($urandom_range(0, hi));
        end
        else if (pick < 40)
        begin
            it.size = $urandom_range(0, 64);
        end
        else if (pick < 60)
        begin
            it.size = $urandom_range(0, 4096);
        end
        else if (pick < 70)
        begin
            it.size = '0;
        end
        else if (pick < 85 && blk_count > 0)
        begin
            // exact fit against an existing block
            it.size = blk_size[$urandom_range(0, hi)];
        end
        else if (pick < 90)
        begin
            it.size = '1;
        end
        return it;
    endfunction

    function automatic logic [31:0] limit_above_top(input int unsigned span);
        logic [32:0] sum;
        sum = {1'b0, heap_top} + span;
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Driver: bursts of transfers separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || transfer_done)
            begin
                transfer_done = 0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    heap_req_t it;
                    it = pending_reqs.pop_front();
                    mode         <= it.mode;
                    request_size <= it.size;
                    block_handle <= it.handle;
                    in_valid     <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: alternating runs of go and stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_run == 0)
            begin
                stall_on  = !stall_on;
                stall_run = stall_on ? $urandom_range(1, 6) :
                            (($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                           $urandom_range(1, 20));
            end
            else
            begin
                stall_run--;
            end
            out_stall <= stall_on;
        end
    end

    // Monitor and predictor: check the result first, then log a new transfer
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_resps.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %0h/%0h/%0h/%0h",
                             $time, status, granted_index, granted_address, was_reused);
                    error_count++;
                end
                else
                begin
                    heap_resp_t er;
                    er = expected_resps.pop_front();
                    check_field("status", 32'(er.status), 32'(status));
                    check_field("granted_index", 32'(er.index), 32'(granted_index));
                    check_field("granted_address", er.addr, granted_address);
                    check_field("was_reused", 32'(er.reused), 32'(was_reused));
                end
            end
            if (in_valid && !in_stall)
            begin
                heap_req_t  rq;
                heap_resp_t rs;
                rq.mode   = mode;
                rq.size   = request_size;
                rq.handle = block_handle;
                allocate_or_free(rq, rs);
                expected_resps.push_back(rs);
                transfer_done = 1;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        mode         = MODE_ALLOC;
        request_size = '0;
        block_handle = '0;
        out_stall    = 1'b0;
        cycle_count  = 0;
        error_count  = 0;
        burst_left   = 0;
        gap_left     = 0;
        stall_on     = 1'b1;
        stall_run    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            blk_start[i] = '0;
            blk_size[i]  = '0;
            blk_free[i]  = 1'b0;
        end
        blk_count = 0;
        limit_reg = HEAP_LIMIT_RST;
        hdr_reg   = HEADER_RST;
        heap_top  = HEAP_BASE_RST;
        n_settings = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset settings, empty table: unknown frees and a carry out
        push_req(MODE_FREE, '1, 5'd31);
        push_req(MODE_FREE, '0, 5'd0);
        push_req(MODE_ALLOC, 32'hFFFF_FFFF, 5'd0);
        wait_drained();

        // base write on an empty table moves the heap top
        write_reg(REG_HEAP_BASE, 32'h8000_0000);
        write_reg(REG_HEAP_LIMIT, 32'h8000_0400);
        write_reg(REG_HEADER_BYTES, 32'd0);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        n_settings++;
        push_req(MODE_ALLOC, 32'd0, 5'd0);
        push_req(MODE_ALLOC, 32'd16, 5'd31);
        push_req(MODE_ALLOC, 32'h100, 5'd0);
        push_req(MODE_FREE, 32'hFFFF_FFFF, 5'd1);
        push_req(MODE_FREE, 32'd0, 5'd1);
        push_req(MODE_ALLOC, 32'd8, 5'd0);
        push_req(MODE_FREE, 32'd0, 5'd0);
        push_req(MODE_ALLOC, 32'd1, 5'd0);
        push_req(MODE_ALLOC, 32'd0, 5'd0);
        push_req(MODE_ALLOC, 32'h400, 5'd0);
        push_req(MODE_FREE, 32'd0, 5'd5);
        push_req(MODE_FREE, 32'd0, 5'd3);
        wait_drained();

        // base write with a populated table leaves the heap top unchanged
        write_reg(REG_HEADER_BYTES, 32'd255);
        write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
        n_settings++;
        push_req(MODE_ALLOC, 32'hFFFF_FFFF, 5'd0);
        push_req(MODE_ALLOC, 32'h7FFF_FFFF, 5'd0);
        push_req(MODE_ALLOC, 32'h10, 5'd0);
        push_req(MODE_FREE, 32'd0, 5'd4);
        push_req(MODE_FREE, 32'd0, 5'd3);
        wait_drained();

        for (int ph = 0; ph < RANDOM_ITEMS / PHASE_ITEMS; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_HEADER_BYTES, 32'd0);
                    write_reg(REG_HEAP_LIMIT, limit_above_top(3000));
                end
                1:
                begin
                    write_reg(REG_HEADER_BYTES, 32'd255);
                    write_reg(REG_HEAP_LIMIT, limit_above_top(60000));
                end
                2:
                begin
                    write_reg(REG_HEADER_BYTES, $urandom_range(0, 255));
                    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
                    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
                end
                3:
                begin
                    write_reg(REG_HEADER_BYTES, $urandom_range(0, 255));
                    write_reg(REG_HEAP_LIMIT, 32'h0000_0000);
                    write_reg(REG_HEAP_BASE, 32'h0000_0000);
                end
                4:
                begin
                    write_reg(REG_HEAP_BASE, $urandom);
                    write_reg(REG_HEAP_LIMIT, $urandom);
                    write_reg(REG_HEADER_BYTES, $urandom_range(0, 255));
                    write_reg(REG_UNUSED, $urandom);
                end
                default:
                begin
                    write_reg(REG_HEADER_BYTES, CFG_W'(HEADER_RST));
                    write_reg(REG_HEAP_LIMIT, $urandom);
                end
            endcase
            n_settings++;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // keep the queue short so generated handles track the table
                while (pending_reqs.size() >= 4)
                begin
                    @(posedge clk);
                    #1;
                end
                pending_reqs.push_back(random_req());
            end
            // hold off until every result of the phase is back
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (expected_resps.size() != 0)
        begin
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, expected_resps.size());
            error_count++;
        end
        $display("Run covered %0d allocates (%0d reused, %0d out of memory or full)",
                 n_alloc, n_reuse, n_nomem);
        $display("and %0d frees (%0d unknown) over %0d register settings, %0d blocks in table.",
                 n_free, n_unknown, n_settings, blk_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator.sv
sim/tb_top.sv
